### src/gh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gh_pkg
// shared constants and the base32 character lookup for the geohash encoder
// ----------------------------------------------------------------------------
package gh_pkg;

    localparam int MAX_CHARS_DEF       = 12;
    localparam int COORD_FRAC_BITS_DEF = 24;
    localparam int BITS_PER_CHAR       = 5;
    localparam int QUEUE_DEPTH         = 2;

    // interval bounds in whole degrees
    localparam int LAT_HALF_DEG = 90;
    localparam int LON_HALF_DEG = 180;
    localparam int LAT_SPAN_DEG = 180;
    localparam int LON_SPAN_DEG = 360;

    // geohash alphabet, first character in the top byte
    localparam logic [255:0] GH_ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

    function automatic logic [7:0] gh_symbol(input logic [BITS_PER_CHAR-1:0] idx);
        logic [BITS_PER_CHAR-1:0] pos;
        pos = 5'd31 - idx;
        return GH_ALPHABET[{pos, 3'b000} +: 8];
    endfunction

endpackage

### src/gh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gh_front
// accepts a coordinate word, flags a bad count and offsets and clamps both axes
// ----------------------------------------------------------------------------
module gh_front
    import gh_pkg::*;
#(
    parameter int MAX_CHARS       = MAX_CHARS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int U_W             = COORD_FRAC_BITS + 9
) (
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [31:0]    i_latitude,
    input  logic signed [32:0]    i_longitude,
    input  logic        [3:0]     i_char_count,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output logic                  o_bad,
    output logic        [U_W-1:0] o_u_lat,
    output logic        [U_W-1:0] o_u_lon
);

    localparam int SW = (COORD_FRAC_BITS + 11 > 35) ? COORD_FRAC_BITS + 11 : 35;

    localparam logic signed [SW-1:0] LAT_HALF = SW'(64'(LAT_HALF_DEG) << COORD_FRAC_BITS);
    localparam logic signed [SW-1:0] LON_HALF = SW'(64'(LON_HALF_DEG) << COORD_FRAC_BITS);
    localparam logic signed [SW-1:0] LAT_SPAN = SW'(64'(LAT_SPAN_DEG) << COORD_FRAC_BITS);
    localparam logic signed [SW-1:0] LON_SPAN = SW'(64'(LON_SPAN_DEG) << COORD_FRAC_BITS);

    logic signed [SW-1:0] lat_off;
    logic signed [SW-1:0] lon_off;

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid & ~i_queue_full;
    assign o_bad      = (i_char_count == 4'd0) || (i_char_count > 4'(MAX_CHARS));

    assign lat_off = {{(SW-32){i_latitude[31]}}, i_latitude} + LAT_HALF;
    assign lon_off = {{(SW-33){i_longitude[32]}}, i_longitude} + LON_HALF;

    // saturate onto [0, span]
    always_comb begin
        if (lat_off[SW-1]) begin
            o_u_lat = '0;
        end else if (lat_off > LAT_SPAN) begin
            o_u_lat = U_W'(LAT_SPAN);
        end else begin
            o_u_lat = U_W'(lat_off);
        end
        if (lon_off[SW-1]) begin
            o_u_lon = '0;
        end else if (lon_off > LON_SPAN) begin
            o_u_lon = U_W'(LON_SPAN);
        end else begin
            o_u_lon = U_W'(lon_off);
        end
    end

endmodule

### src/gh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gh_queue
// short first-in first-out queue between the front and back parts
// ----------------------------------------------------------------------------
module gh_queue
    import gh_pkg::*;
#(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [DW-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### src/gh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gh_back
// bisects both intervals five steps a cycle unless stalled; one character word
// ----------------------------------------------------------------------------
module gh_back
    import gh_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int U_W             = COORD_FRAC_BITS + 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  logic           i_bad,
    input  logic [3:0]     i_count,
    input  logic [U_W-1:0] i_u_lat,
    input  logic [U_W-1:0] i_u_lon,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_symbol,
    output logic           o_last,
    output logic           o_bad_count
);

    localparam int RES_W = U_W + 1;

    localparam logic [RES_W-1:0] LAT_SPAN = RES_W'(64'(LAT_SPAN_DEG) << COORD_FRAC_BITS);
    localparam logic [RES_W-1:0] LON_SPAN = RES_W'(64'(LON_SPAN_DEG) << COORD_FRAC_BITS);

    logic             r_busy;
    logic             r_bad;
    logic [3:0]       r_left;
    logic             r_lon_turn;
    logic [RES_W-1:0] r_lat;
    logic [RES_W-1:0] r_lon;
    logic             r_out_valid;
    logic [7:0]       r_symbol;
    logic             r_last;
    logic             r_bad_count;

    logic [RES_W-1:0]         n_lat;
    logic [RES_W-1:0]         n_lon;
    logic [BITS_PER_CHAR-1:0] n_idx;
    logic                     advance;
    logic                     emit;
    logic                     final_char;

    // one bisection: double the residue and compare against the span
    function automatic logic bisect(inout logic [RES_W-1:0] res,
                                    input logic [RES_W-1:0] span);
        logic [RES_W-1:0] d;
        d = {res[RES_W-2:0], 1'b0};
        if (d > span) begin
            res = d - span;
            return 1'b1;
        end
        res = d;
        return 1'b0;
    endfunction

    always_comb begin
        logic turn;
        logic bit_v;
        n_lat = r_lat;
        n_lon = r_lon;
        n_idx = '0;
        turn  = r_lon_turn;
        for (int b = 0; b < BITS_PER_CHAR; b++) begin
            if (turn) begin
                bit_v = bisect(n_lon, LON_SPAN);
            end else begin
                bit_v = bisect(n_lat, LAT_SPAN);
            end
            n_idx = {n_idx[BITS_PER_CHAR-2:0], bit_v};
            turn  = ~turn;
        end
    end

    assign advance    = ~r_out_valid | ~i_out_stall;
    assign emit       = r_busy & advance;
    assign final_char = r_bad | (r_left == 4'd1);
    assign o_pop      = ~i_empty & (~r_busy | (emit & final_char));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && final_char) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (advance) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bad      <= i_bad;
            r_left     <= i_count;
            r_lon_turn <= 1'b1;
            r_lat      <= RES_W'(i_u_lat);
            r_lon      <= RES_W'(i_u_lon);
        end else if (emit) begin
            r_left     <= r_left - 4'd1;
            r_lon_turn <= ~r_lon_turn;
            r_lat      <= n_lat;
            r_lon      <= n_lon;
        end
        if (emit) begin
            r_symbol    <= r_bad ? 8'd0 : gh_symbol(n_idx);
            r_last      <= final_char;
            r_bad_count <= r_bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_last      = r_last;
    assign o_bad_count = r_bad_count;

endmodule

### src/geohash_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geohash_encoder
// base32 geohash of one coordinate pair, one character per output word
// ----------------------------------------------------------------------------
// path: after the input word is accepted, the first character word passes the
//   queue write, then the back part load, then the output register
// flow: one character per cycle while the output is not stalled; a bad count
//   gives a single error word; the next item loads with the last character
// reset: synchronous, active low; empties the queue, idles the back part and
//   clears the output valid; no clearing pass
// ----------------------------------------------------------------------------
module geohash_encoder
    import gh_pkg::*;
#(
    parameter int MAX_CHARS       = MAX_CHARS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input word: one coordinate pair and a character count
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_latitude,
    input  logic signed [32:0] i_longitude,
    input  logic        [3:0]  i_char_count,
    // output word: one geohash character
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic        [7:0]  o_symbol,
    output logic               o_last,
    output logic               o_bad_count
);

    // clamped offset coordinate lies in [0, span], span below 2^(frac+9)
    localparam int U_W = COORD_FRAC_BITS + 9;
    // queue entry: bad flag, count, latitude, longitude
    localparam int DW  = 1 + 4 + 2 * U_W;

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;
    logic           f_bad;
    logic [U_W-1:0] f_u_lat;
    logic [U_W-1:0] f_u_lon;
    logic [DW-1:0]  q_wr_data;
    logic [DW-1:0]  q_rd_data;

    // front: handshake, count check, offset and saturation onto the interval
    gh_front #(
        .MAX_CHARS       (MAX_CHARS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .U_W             (U_W)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_latitude   (i_latitude),
        .i_longitude  (i_longitude),
        .i_char_count (i_char_count),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_bad        (f_bad),
        .o_u_lat      (f_u_lat),
        .o_u_lon      (f_u_lon)
    );

    assign q_wr_data = {f_bad, i_char_count, f_u_lat, f_u_lon};

    // short queue so the front keeps taking words while characters drain
    gh_queue #(
        .DW (DW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wr_data),
        .i_pop   (pop),
        .o_data  (q_rd_data),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    // back: residue bisection, five bits per character, registered output
    gh_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .U_W             (U_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (queue_empty),
        .i_bad       (q_rd_data[DW-1]),
        .i_count     (q_rd_data[DW-2 -: 4]),
        .i_u_lat     (q_rd_data[2*U_W-1 -: U_W]),
        .i_u_lon     (q_rd_data[U_W-1:0]),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_symbol    (o_symbol),
        .o_last      (o_last),
        .o_bad_count (o_bad_count)
    );

endmodule

### src/gh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gh_checker
// port-level checks on the geohash encoder input and output words
// ----------------------------------------------------------------------------
module gh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic signed [31:0] i_latitude,
    input logic signed [32:0] i_longitude,
    input logic        [3:0]  i_char_count,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic        [7:0]  o_symbol,
    input logic               o_last,
    input logic               o_bad_count
);

    // an error word is a lone last word with a null symbol
    a_bad_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_count |-> o_last && (o_symbol == 8'd0))
        else $error("error word malformed");

    // a character word always carries a code no lower than the alphabet's '0'
    a_char_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_bad_count |-> (o_symbol >= 8'h30))
        else $error("character word has no alphabet code");

    // reset leaves no output word pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_symbol)
            && $stable(o_last) && $stable(o_bad_count))
        else $error("stalled output word changed");

    // a stalled input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_latitude)
            && $stable(i_longitude) && $stable(i_char_count))
        else $error("stalled input word changed");

endmodule

bind geohash_encoder gh_checker u_gh_checker (.*);
